// ----- rtl/core/ild_pkg.sv -----
// Shared types, constants and register indexes of the ID-list interval decoder.
package ild_pkg;

   // Default parameter values for the top level.
   localparam int INDEX_WIDTH_DEF = 32;
   localparam int PID_WIDTH_DEF   = 16;

   // Fixed field widths of the stream payloads and registers.
   localparam int PID_OUT_W   = 16;
   localparam int INDEX_OUT_W = 32;
   localparam int BYTES_W     = 24;
   localparam int BIT_TOTAL_W = 27;
   localparam int SHIFT_W     = 32;
   localparam int COUNT_W     = 6;
   localparam int PBITS_W     = 5;
   localparam int XBITS_W     = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SELF_ID     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PID_BITS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_BITS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUFFIX_BITS = 2'd3;

   // Register reset values.
   localparam logic [PID_OUT_W-1:0] SELF_ID_RST     = 16'd0;
   localparam logic [PBITS_W-1:0]   PID_BITS_RST    = 5'd3;
   localparam logic [XBITS_W-1:0]   PREFIX_BITS_RST = 6'd8;
   localparam logic [XBITS_W-1:0]   SUFFIX_BITS_RST = 6'd5;

   // Result kinds carried on tuser.
   localparam logic KIND_INTERVAL = 1'b0;
   localparam logic KIND_END      = 1'b1;

   typedef enum logic [3:0] {
      PH_LGROUP   = 4'd0,
      PH_PREFIX   = 4'd1,
      PH_RUNFLAG  = 4'd2,
      PH_RUNSTART = 4'd3,
      PH_RUNEND   = 4'd4,
      PH_SGLFLAG  = 4'd5,
      PH_SGLSUF   = 4'd6,
      PH_RSECTION = 4'd7,
      PH_PID      = 4'd8,
      PH_RMORE    = 4'd9
   } phase_type;

   typedef struct packed {
      logic [PID_OUT_W-1:0] self_id;
      logic [PBITS_W-1:0]   pid_bits;
      logic [XBITS_W-1:0]   prefix_bits;
      logic [XBITS_W-1:0]   suffix_bits;
   } cfg_type;

   typedef struct packed {
      logic                   item_kind;
      logic [PID_OUT_W-1:0]   owner_pid;
      logic [INDEX_OUT_W-1:0] first_index;
      logic [INDEX_OUT_W-1:0] last_index;
      logic [BYTES_W-1:0]     bytes_used;
   } rsp_type;

endpackage

// ----- rtl/core/ild_csr.sv -----
// Configuration registers of the ID-list interval decoder.
module ild_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ild_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ild_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output ild_pkg::cfg_type                     cfg
);

   ild_pkg::cfg_type cfg_ff;
   ild_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ild_pkg::CSR_SELF_ID:     cfg_in.self_id     = csr_wdata;
            ild_pkg::CSR_PID_BITS:    cfg_in.pid_bits    = csr_wdata[ild_pkg::PBITS_W-1:0];
            ild_pkg::CSR_PREFIX_BITS: cfg_in.prefix_bits = csr_wdata[ild_pkg::XBITS_W-1:0];
            ild_pkg::CSR_SUFFIX_BITS: cfg_in.suffix_bits = csr_wdata[ild_pkg::XBITS_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.self_id     <= ild_pkg::SELF_ID_RST;
         cfg_ff.pid_bits    <= ild_pkg::PID_BITS_RST;
         cfg_ff.prefix_bits <= ild_pkg::PREFIX_BITS_RST;
         cfg_ff.suffix_bits <= ild_pkg::SUFFIX_BITS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/ild_parser.sv -----
// Bit-serial parser state machine that turns code bits into interval results.
module ild_parser #(
   parameter int INDEX_WIDTH = ild_pkg::INDEX_WIDTH_DEF,
   parameter int PID_WIDTH   = ild_pkg::PID_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               code_bit,
   input  ild_pkg::cfg_type   cfg,
   output logic               emit,
   output ild_pkg::rsp_type   res
);

   localparam int PID_KEEP = (PID_WIDTH < ild_pkg::PID_OUT_W) ? PID_WIDTH : ild_pkg::PID_OUT_W;

   ild_pkg::phase_type                  phase_ff, phase_in;
   logic [ild_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [ild_pkg::SHIFT_W-1:0]         shift_ff, shift_in;
   logic [INDEX_WIDTH-1:0]              prefix_ff, prefix_in;
   logic [INDEX_WIDTH-1:0]              run_first_ff, run_first_in;
   logic [ild_pkg::PID_OUT_W-1:0]       pid_ff, pid_in;
   logic [ild_pkg::BIT_TOTAL_W-1:0]     bit_total_ff, bit_total_in;
   logic                                in_remote_ff, in_remote_in;

   logic [ild_pkg::SHIFT_W-1:0]         shift_next;
   logic [ild_pkg::COUNT_W-1:0]         count_next;
   logic [INDEX_WIDTH-1:0]              field_index;
   logic [ild_pkg::BIT_TOTAL_W-1:0]     bit_total_inc;
   logic [ild_pkg::BIT_TOTAL_W:0]       bits_round;
   logic [ild_pkg::BIT_TOTAL_W-3:0]     bytes_raw;
   logic                                done_prefix, done_suffix, done_pid;

   always_comb begin
      shift_next  = {shift_ff[ild_pkg::SHIFT_W-2:0], code_bit};
      count_next  = count_ff + 1'b1;
      field_index = shift_next[INDEX_WIDTH-1:0];
      done_prefix = count_next >= cfg.prefix_bits;
      done_suffix = count_next >= cfg.suffix_bits;
      done_pid    = count_next >= {1'b0, cfg.pid_bits};

      bit_total_inc = (bit_total_ff != '1) ? bit_total_ff + 1'b1 : bit_total_ff;
      bits_round    = {1'b0, bit_total_inc} + (ild_pkg::BIT_TOTAL_W+1)'(7);
      bytes_raw     = bits_round[ild_pkg::BIT_TOTAL_W:3];

      phase_in     = phase_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      prefix_in    = prefix_ff;
      run_first_in = run_first_ff;
      pid_in       = pid_ff;
      bit_total_in = bit_total_inc;
      in_remote_in = in_remote_ff;

      emit            = 1'b0;
      res.item_kind   = ild_pkg::KIND_INTERVAL;
      res.owner_pid   = in_remote_ff ? pid_ff : cfg.self_id;
      res.first_index = '0;
      res.last_index  = '0;
      res.bytes_used  = '0;

      unique case (phase_ff)
         ild_pkg::PH_LGROUP, ild_pkg::PH_RMORE: begin
            if (phase_ff == ild_pkg::PH_LGROUP) in_remote_in = 1'b0;
            if (code_bit) begin
               // Open a prefix group; an empty prefix completes at once.
               if (cfg.prefix_bits == '0) begin
                  prefix_in = '0;
                  phase_in  = ild_pkg::PH_RUNFLAG;
               end else begin
                  phase_in = ild_pkg::PH_PREFIX;
                  count_in = '0;
                  shift_in = '0;
               end
            end else begin
               phase_in = ild_pkg::PH_RSECTION;
            end
         end
         ild_pkg::PH_PREFIX: begin
            shift_in = shift_next;
            count_in = count_next;
            if (done_prefix) begin
               // A shift of the full index width or more leaves zero.
               prefix_in = field_index << cfg.suffix_bits;
               phase_in  = ild_pkg::PH_RUNFLAG;
            end
         end
         ild_pkg::PH_RUNFLAG: begin
            if (!code_bit) begin
               phase_in = ild_pkg::PH_SGLFLAG;
            end else if (cfg.suffix_bits == '0) begin
               emit            = 1'b1;
               res.first_index = ild_pkg::INDEX_OUT_W'(prefix_ff);
               res.last_index  = ild_pkg::INDEX_OUT_W'(prefix_ff);
            end else begin
               phase_in = ild_pkg::PH_RUNSTART;
               count_in = '0;
               shift_in = '0;
            end
         end
         ild_pkg::PH_RUNSTART: begin
            shift_in = shift_next;
            count_in = count_next;
            if (done_suffix) begin
               run_first_in = field_index | prefix_ff;
               phase_in     = ild_pkg::PH_RUNEND;
               count_in     = '0;
               shift_in     = '0;
            end
         end
         ild_pkg::PH_RUNEND: begin
            shift_in = shift_next;
            count_in = count_next;
            if (done_suffix) begin
               phase_in        = ild_pkg::PH_RUNFLAG;
               emit            = 1'b1;
               res.first_index = ild_pkg::INDEX_OUT_W'(run_first_ff);
               res.last_index  = ild_pkg::INDEX_OUT_W'(field_index | prefix_ff);
            end
         end
         ild_pkg::PH_SGLFLAG: begin
            if (code_bit) begin
               phase_in = in_remote_ff ? ild_pkg::PH_RMORE : ild_pkg::PH_LGROUP;
            end else if (cfg.suffix_bits == '0) begin
               emit            = 1'b1;
               res.first_index = ild_pkg::INDEX_OUT_W'(prefix_ff);
               res.last_index  = ild_pkg::INDEX_OUT_W'(prefix_ff);
            end else begin
               phase_in = ild_pkg::PH_SGLSUF;
               count_in = '0;
               shift_in = '0;
            end
         end
         ild_pkg::PH_SGLSUF: begin
            shift_in = shift_next;
            count_in = count_next;
            if (done_suffix) begin
               phase_in        = ild_pkg::PH_SGLFLAG;
               emit            = 1'b1;
               res.first_index = ild_pkg::INDEX_OUT_W'(field_index | prefix_ff);
               res.last_index  = ild_pkg::INDEX_OUT_W'(field_index | prefix_ff);
            end
         end
         ild_pkg::PH_RSECTION: begin
            if (code_bit) begin
               in_remote_in = 1'b1;
               if (cfg.pid_bits == '0) begin
                  pid_in = '0;
                  if (cfg.prefix_bits == '0) begin
                     prefix_in = '0;
                     phase_in  = ild_pkg::PH_RUNFLAG;
                  end else begin
                     phase_in = ild_pkg::PH_PREFIX;
                     count_in = '0;
                     shift_in = '0;
                  end
               end else begin
                  phase_in = ild_pkg::PH_PID;
                  count_in = '0;
                  shift_in = '0;
               end
            end else begin
               // End of code: report the byte count and restart the parse.
               emit          = 1'b1;
               res.item_kind = ild_pkg::KIND_END;
               res.owner_pid = '0;
               res.bytes_used = bytes_raw[ild_pkg::BYTES_W] ? '1 :
                                bytes_raw[ild_pkg::BYTES_W-1:0];
               phase_in      = ild_pkg::PH_LGROUP;
               in_remote_in  = 1'b0;
               bit_total_in  = '0;
            end
         end
         ild_pkg::PH_PID: begin
            shift_in = shift_next;
            count_in = count_next;
            if (done_pid) begin
               pid_in = ild_pkg::PID_OUT_W'(shift_next[PID_KEEP-1:0]);
               if (cfg.prefix_bits == '0) begin
                  prefix_in = '0;
                  phase_in  = ild_pkg::PH_RUNFLAG;
               end else begin
                  phase_in = ild_pkg::PH_PREFIX;
                  count_in = '0;
                  shift_in = '0;
               end
            end
         end
         default: begin
            phase_in = ild_pkg::PH_LGROUP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ild_pkg::PH_LGROUP;
         count_ff     <= '0;
         shift_ff     <= '0;
         prefix_ff    <= '0;
         run_first_ff <= '0;
         pid_ff       <= '0;
         bit_total_ff <= '0;
         in_remote_ff <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         prefix_ff    <= prefix_in;
         run_first_ff <= run_first_in;
         pid_ff       <= pid_in;
         bit_total_ff <= bit_total_in;
         in_remote_ff <= in_remote_in;
      end
   end

`ifndef ASSERT_OFF
   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      emit |-> (phase_ff == ild_pkg::PH_RUNFLAG || phase_ff == ild_pkg::PH_RUNEND ||
                phase_ff == ild_pkg::PH_SGLFLAG || phase_ff == ild_pkg::PH_SGLSUF ||
                phase_ff == ild_pkg::PH_RSECTION))
      else $error("result raised in a phase that cannot complete an item");

   a_remote_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ild_pkg::PH_PID || phase_ff == ild_pkg::PH_RMORE) |-> in_remote_ff)
      else $error("remote-only phase reached outside a remote section");

   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      (step && emit && res.item_kind == ild_pkg::KIND_END) |=>
         (phase_ff == ild_pkg::PH_LGROUP && bit_total_ff == '0 && !in_remote_ff))
      else $error("parser did not restart after end of code");
`endif

endmodule

// ----- rtl/core/id_list_interval_decoder.sv -----
// A code bit is held in an input register; a result it yields is registered at the output.
// Throughput: one code bit per cycle; the single parser step between input and result registers
// sets that rate; only a bit that yields a result waits on a full, unread result register.
// Reset: synchronous, active high; parser returns to the local group flag, counters clear, and
// the configuration registers take self_id 0, pid_bits 3, prefix_bits 8, suffix_bits 5.
module id_list_interval_decoder #(
   parameter int INDEX_WIDTH = ild_pkg::INDEX_WIDTH_DEF,
   parameter int PID_WIDTH   = ild_pkg::PID_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   // Code bit stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [0] code_bit, [7:1] unused

   // Decoded intervals and end-of-code results.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [103:0]                      rsp_tdata,   // owner_pid, first_index,
                                                          // last_index, bytes_used
   output logic                              rsp_tuser,   // [0] item_kind

   // Configuration write port.
   input  logic                              csr_we,
   input  logic [ild_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ild_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   ild_pkg::cfg_type cfg;
   ild_pkg::rsp_type res;
   ild_pkg::rsp_type rsp_data_ff;

   logic in_valid_ff;
   logic in_bit_ff;
   logic rsp_valid_ff;
   logic emit;
   logic out_free;
   logic advance;

   ild_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ild_parser #(
      .INDEX_WIDTH (INDEX_WIDTH),
      .PID_WIDTH   (PID_WIDTH)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .code_bit (in_bit_ff),
      .cfg      (cfg),
      .emit     (emit),
      .res      (res)
   );

   // The held bit is parsed once the result slot can take what it produces.
   // A bit that produces nothing never waits for the result side.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!emit || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_bit_ff <= req_tdata[0];
      end
   end

   // Result register: loaded by a parser step that completes an item,
   // emptied by a transfer on the result side.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.item_kind;
   assign rsp_tdata  = {rsp_data_ff.bytes_used, rsp_data_ff.last_index,
                        rsp_data_ff.first_index, rsp_data_ff.owner_pid};

`ifndef ASSERT_OFF
   a_end_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.item_kind == ild_pkg::KIND_END) |->
         (rsp_data_ff.bytes_used != '0 && rsp_data_ff.owner_pid == '0))
      else $error("end-of-code result without a byte count");

   a_interval_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.item_kind == ild_pkg::KIND_INTERVAL) |->
         rsp_data_ff.bytes_used == '0)
      else $error("interval result carries a byte count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |-> out_free)
      else $error("result register overwritten before its transfer");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the bit-serial ID-list interval decoder.
module tb;

   // The run is stopped here if the stream ever hangs.
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata  = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          csr_we     = 1'b0;
   logic [ild_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ild_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   id_list_interval_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [0] code_bit, [7:1] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [15:0] owner_pid, [47:16] first_index,
                                  // [79:48] last_index, [103:80] bytes_used
      .rsp_tuser  (rsp_tuser),    // [0] item_kind
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Our own copy of the decoder: configuration as last written, and parser state.
   logic [15:0] cfg_self     = ild_pkg::SELF_ID_RST;
   logic [4:0]  cfg_pid_w    = ild_pkg::PID_BITS_RST;
   logic [5:0]  cfg_prefix_w = ild_pkg::PREFIX_BITS_RST;
   logic [5:0]  cfg_suffix_w = ild_pkg::SUFFIX_BITS_RST;

   ild_pkg::phase_type dec_phase = ild_pkg::PH_LGROUP;
   logic [5:0]  dec_count     = '0;
   logic [31:0] dec_shift     = '0;
   logic [31:0] dec_prefix    = '0;
   logic [31:0] dec_run_first = '0;
   logic [15:0] dec_pid       = '0;
   logic [26:0] dec_bits      = '0;
   logic        dec_remote    = 1'b0;

   // Results predicted for accepted code bits, oldest first.
   ild_pkg::rsp_type pending_decodes[$];

   int          mismatches   = 0;
   int          results_seen = 0;
   int          bits_sent    = 0;
   int unsigned cycle_count  = 0;

   // When calm is set, neither side inserts idle cycles.
   logic        calm = 1'b0;

   // A long receiver hold is requested by bumping hold_seq; the receiver process
   // notices the change and counts the hold down itself.
   int          hold_seq  = 0;
   int          hold_len  = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic void open_field(input ild_pkg::phase_type p);
      dec_phase = p;
      dec_count = '0;
      dec_shift = '0;
   endfunction

   // The prefix is placed above the suffix. A shift of 32 or more pushes it out
   // entirely; the upper bits of a wide prefix are shifted out.
   function automatic void load_prefix(input logic [31:0] raw);
      if (cfg_suffix_w >= 6'd32) dec_prefix = '0;
      else dec_prefix = raw << cfg_suffix_w;
   endfunction

   function automatic void open_prefix();
      if (cfg_prefix_w == 6'd0) begin
         load_prefix('0);
         dec_phase = ild_pkg::PH_RUNFLAG;
      end else begin
         open_field(ild_pkg::PH_PREFIX);
      end
   endfunction

   // Shifts one bit into the current field and says whether it is now complete.
   // The width is read on every bit, so a width changed mid-field applies at once.
   function automatic logic shift_in(input logic b, input logic [5:0] w);
      dec_shift = {dec_shift[30:0], b};
      dec_count = dec_count + 6'd1;
      return dec_count >= w;
   endfunction

   function automatic ild_pkg::rsp_type interval(input logic [31:0] first,
                                                 input logic [31:0] last);
      ild_pkg::rsp_type r;
      r.item_kind   = ild_pkg::KIND_INTERVAL;
      r.owner_pid   = dec_remote ? dec_pid : cfg_self;
      r.first_index = first;
      r.last_index  = last;
      r.bytes_used  = '0;
      return r;
   endfunction

   // Advances the parser by one code bit; returns 1 when the bit yields a result.
   function automatic logic decode_bit(input logic b, output ild_pkg::rsp_type r);
      logic        found;
      logic [31:0] v;
      logic [27:0] bsum;
      found = 1'b0;
      r     = '0;
      if (dec_bits != '1) dec_bits = dec_bits + 27'd1;
      case (dec_phase)
         ild_pkg::PH_LGROUP: begin
            dec_remote = 1'b0;
            if (b) open_prefix();
            else dec_phase = ild_pkg::PH_RSECTION;
         end
         ild_pkg::PH_PREFIX: begin
            if (shift_in(b, cfg_prefix_w)) begin
               load_prefix(dec_shift);
               dec_phase = ild_pkg::PH_RUNFLAG;
            end
         end
         ild_pkg::PH_RUNFLAG: begin
            if (!b) begin
               dec_phase = ild_pkg::PH_SGLFLAG;
            end else if (cfg_suffix_w == 6'd0) begin
               // A zero-width suffix: the flag alone completes the run.
               r     = interval(dec_prefix, dec_prefix);
               found = 1'b1;
            end else begin
               open_field(ild_pkg::PH_RUNSTART);
            end
         end
         ild_pkg::PH_RUNSTART: begin
            if (shift_in(b, cfg_suffix_w)) begin
               dec_run_first = dec_shift | dec_prefix;
               open_field(ild_pkg::PH_RUNEND);
            end
         end
         ild_pkg::PH_RUNEND: begin
            if (shift_in(b, cfg_suffix_w)) begin
               dec_phase = ild_pkg::PH_RUNFLAG;
               r     = interval(dec_run_first, dec_shift | dec_prefix);
               found = 1'b1;
            end
         end
         ild_pkg::PH_SGLFLAG: begin
            if (b) begin
               dec_phase = dec_remote ? ild_pkg::PH_RMORE : ild_pkg::PH_LGROUP;
            end else if (cfg_suffix_w == 6'd0) begin
               r     = interval(dec_prefix, dec_prefix);
               found = 1'b1;
            end else begin
               open_field(ild_pkg::PH_SGLSUF);
            end
         end
         ild_pkg::PH_SGLSUF: begin
            if (shift_in(b, cfg_suffix_w)) begin
               v         = dec_shift | dec_prefix;
               dec_phase = ild_pkg::PH_SGLFLAG;
               r     = interval(v, v);
               found = 1'b1;
            end
         end
         ild_pkg::PH_RSECTION: begin
            if (b) begin
               dec_remote = 1'b1;
               if (cfg_pid_w == 5'd0) begin
                  dec_pid = '0;
                  open_prefix();
               end else begin
                  open_field(ild_pkg::PH_PID);
               end
            end else begin
               // End of code: report the byte count and start over.
               bsum = {1'b0, dec_bits} + 28'd7;
               bsum = bsum >> 3;
               r.item_kind  = ild_pkg::KIND_END;
               r.bytes_used = (bsum > 28'hFFFFFF) ? 24'hFFFFFF : bsum[23:0];
               found      = 1'b1;
               dec_phase  = ild_pkg::PH_LGROUP;
               dec_remote = 1'b0;
               dec_bits   = '0;
            end
         end
         ild_pkg::PH_PID: begin
            if (shift_in(b, {1'b0, cfg_pid_w})) begin
               dec_pid = dec_shift[15:0];
               open_prefix();
            end
         end
         ild_pkg::PH_RMORE: begin
            if (b) open_prefix();
            else dec_phase = ild_pkg::PH_RSECTION;
         end
         default: dec_phase = ild_pkg::PH_LGROUP;
      endcase
      return found;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 50)
         $display("mismatch on result %0d, %s: got %h, expected %h",
                  results_seen, what, got, want);
   endtask

   // Every result transfer is compared field by field with the oldest prediction.
   always @(posedge clock) begin : check_results
      ild_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_decodes.size() == 0) begin
            report_mismatch("result with nothing pending", {31'b0, rsp_tuser}, '0);
         end else begin
            want = pending_decodes.pop_front();
            if (rsp_tuser != want.item_kind)
               report_mismatch("item_kind", {31'b0, rsp_tuser}, {31'b0, want.item_kind});
            if (rsp_tdata[15:0] != want.owner_pid)
               report_mismatch("owner_pid", {16'b0, rsp_tdata[15:0]}, {16'b0, want.owner_pid});
            if (rsp_tdata[47:16] != want.first_index)
               report_mismatch("first_index", rsp_tdata[47:16], want.first_index);
            if (rsp_tdata[79:48] != want.last_index)
               report_mismatch("last_index", rsp_tdata[79:48], want.last_index);
            if (rsp_tdata[103:80] != want.bytes_used)
               report_mismatch("bytes_used", {8'b0, rsp_tdata[103:80]}, {8'b0, want.bytes_used});
         end
      end
   end

   // The receiver stalls at random about 15 times in a hundred, not at all while
   // calm is set, and holds off completely for a requested stretch of cycles.
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 15);
      end
   end

   // A hung stream ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_decodes.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Offers one code bit, waits for its transfer and records what it should yield.
   // The valid stays high afterward so that back-to-back bits need no extra edge.
   task automatic send_bit(input logic b);
      ild_pkg::rsp_type r;
      if (!calm && $urandom_range(0, 99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, b};
      do @(posedge clock); while (!req_tready);
      bits_sent++;
      if (decode_bit(b, r)) pending_decodes.push_back(r);
   endtask

   // Sends the low w bits of v, most significant first.
   task automatic send_field(input logic [31:0] v, input int w);
      for (int i = w - 1; i >= 0; i--) send_bit(v[i]);
   endtask

   // Stops offering bits, waits for every predicted result, then lets the pipeline
   // settle so that a register write cannot overtake a bit still in flight.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all four registers, one per cycle, and mirrors them in the predictor.
   task automatic load_config(input logic [15:0] sid, input logic [4:0] pw,
                              input logic [5:0] xw, input logic [5:0] sw);
      logic [ild_pkg::CSR_INDEX_W-1:0] idx [4];
      logic [15:0]                     val [4];
      idx[0] = ild_pkg::CSR_SELF_ID;     val[0] = sid;
      idx[1] = ild_pkg::CSR_PID_BITS;    val[1] = {11'b0, pw};
      idx[2] = ild_pkg::CSR_PREFIX_BITS; val[2] = {10'b0, xw};
      idx[3] = ild_pkg::CSR_SUFFIX_BITS; val[3] = {10'b0, sw};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         case (idx[i])
            ild_pkg::CSR_SELF_ID:     cfg_self     = val[i];
            ild_pkg::CSR_PID_BITS:    cfg_pid_w    = val[i][4:0];
            ild_pkg::CSR_PREFIX_BITS: cfg_prefix_w = val[i][5:0];
            ild_pkg::CSR_SUFFIX_BITS: cfg_suffix_w = val[i][5:0];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // Field values lean toward the all-zeros and all-ones extremes.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // One prefix group after its opening flag: prefix, runs, singles.
   // Runs mostly ascend; about one in ten is reversed on purpose.
   task automatic send_group(input int runs, input int singles);
      logic [31:0] mask, a, c, t;
      mask = (cfg_suffix_w >= 6'd32) ? '1 : ((32'd1 << cfg_suffix_w) - 32'd1);
      send_field(pick_value(), cfg_prefix_w);
      repeat (runs) begin
         a = pick_value() & mask;
         c = pick_value() & mask;
         if ((a > c) != ($urandom_range(0, 9) == 0)) begin
            t = a; a = c; c = t;
         end
         send_bit(1'b1);
         send_field(a, cfg_suffix_w);
         send_field(c, cfg_suffix_w);
      end
      send_bit(1'b0);
      repeat (singles) begin
         send_bit(1'b0);
         send_field(pick_value(), cfg_suffix_w);
      end
      send_bit(1'b1);
   endtask

   // A complete well-formed code with random content.
   task automatic send_code(input int local_groups, input int sections, input int most);
      int groups;
      repeat (local_groups) begin
         send_bit(1'b1);
         send_group($urandom_range(0, most), $urandom_range(0, most));
      end
      send_bit(1'b0);
      repeat (sections) begin
         send_bit(1'b1);
         send_field(pick_value(), cfg_pid_w);
         groups = $urandom_range(1, 2);
         for (int g = 0; g < groups; g++) begin
            send_group($urandom_range(0, most), $urandom_range(0, most));
            send_bit(g != groups - 1);
         end
      end
      send_bit(1'b0);
   endtask

   // Steers the parser from wherever it stands to the end of the code: zeros
   // finish every field and close every section, except in the singles phase,
   // where a zero would open another single and a one closes the group.
   task automatic finish_code();
      while (!(dec_phase == ild_pkg::PH_LGROUP && dec_bits == '0))
         send_bit(dec_phase == ild_pkg::PH_SGLFLAG);
   endtask

   task automatic random_config();
      logic [4:0] pw;
      logic [5:0] xw, sw;
      case ($urandom_range(0, 9))
         0:       pw = 5'd0;
         1:       pw = 5'd16;
         default: pw = 5'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 11))
         0:       xw = 6'd0;
         1:       xw = 6'd32;
         2:       xw = 6'($urandom_range(9, 31));
         default: xw = 6'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 11))
         0:       sw = 6'd0;
         1:       sw = 6'd32;
         2:       sw = 6'($urandom_range(9, 31));
         default: sw = 6'($urandom_range(1, 6));
      endcase
      load_config(16'($urandom), pw, xw, sw);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // With the reset settings: two empty codes in a row, so the byte count must
   // restart, then a full code with local and remote sections.
   task automatic test_reset_settings();
      send_field(32'b00, 2);
      send_field(32'b00, 2);
      send_code(2, 2, 2);
      wait_idle();
   endtask

   // All widths zero: every field completes at once, so the run and single flags
   // emit intervals directly and the remote id is zero.
   task automatic test_zero_widths();
      load_config(16'hFFFF, 5'd0, 6'd0, 6'd0);
      send_field(32'b1110010100100, 13);
      wait_idle();
   endtask

   // Full-width fields: a suffix of 32 bits pushes the prefix out entirely, and a
   // prefix wider than the room left above the suffix loses its upper bits.
   task automatic test_wide_fields();
      load_config(16'h0000, 5'd16, 6'd32, 6'd32);
      send_bit(1'b1);
      send_field('1, 32);
      send_bit(1'b1);
      send_field('0, 32);
      send_field('1, 32);
      send_bit(1'b0);
      send_bit(1'b0);
      send_field(32'h8000_0001, 32);
      send_bit(1'b1);
      send_bit(1'b0);
      send_bit(1'b1);
      send_field(32'h0000_FFFF, 16);
      send_field(32'h1234_5678, 32);
      send_bit(1'b0);
      send_bit(1'b0);
      send_field('1, 32);
      send_bit(1'b1);
      send_bit(1'b0);
      send_bit(1'b0);
      wait_idle();
      load_config(16'hA5A5, 5'd1, 6'd24, 6'd16);
      send_code(1, 1, 2);
      wait_idle();
      load_config(16'h5A5A, 5'd16, 6'd0, 6'd32);
      send_code(1, 1, 2);
      wait_idle();
   endtask

   // A run whose end lies below its start must come out unchanged.
   task automatic test_reversed_run();
      load_config(16'h0042, 5'd3, 6'd8, 6'd5);
      send_bit(1'b1);
      send_field(32'h5A, 8);
      send_bit(1'b1);
      send_field(32'd20, 5);
      send_field(32'd3, 5);
      send_field(32'b0100, 4);
      wait_idle();
   endtask

   // The suffix width changes while a suffix is half read; the new width applies
   // from the next bit on. The block is idle at both writes; at the first one only
   // the parser stands inside a field.
   task automatic test_width_change_mid_code();
      load_config(16'h1234, 5'd3, 6'd8, 6'd5);
      send_bit(1'b1);
      send_field(32'hC3, 8);
      send_bit(1'b1);
      send_field(32'b10, 2);
      wait_idle();
      load_config(cfg_self, cfg_pid_w, cfg_prefix_w, 6'd3);
      send_field(32'b1011, 4);
      wait_idle();
      load_config(cfg_self, cfg_pid_w, cfg_prefix_w, 6'd7);
      send_field(32'b110, 3);
      finish_code();
      wait_idle();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering a
   // code full of intervals, so the block fills and stalls its input.
   task automatic test_long_hold();
      load_config(16'h0777, 5'd2, 6'd1, 6'd2);
      hold_len = 300;
      hold_seq++;
      send_code(2, 2, 6);
      wait_idle();
   endtask

   // Mostly well-formed codes with random content and settings; about one in ten
   // is a burst of random bits that is then steered to the end of the code.
   // The first stretch runs without any idle cycles on either side.
   task automatic test_random_codes();
      int start;
      start = bits_sent;
      calm  = 1'b1;
      while (bits_sent - start < 300) begin
         if (bits_sent - start > 120) calm = 1'b0;
         if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            random_config();
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 40)) send_bit(1'($urandom_range(0, 1)));
            finish_code();
         end else begin
            send_code($urandom_range(0, 2), $urandom_range(0, 2), 3);
         end
      end
      calm = 1'b0;
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_zero_widths();
      test_wide_fields();
      test_reversed_run();
      test_width_change_mid_code();
      test_long_hold();
      test_random_codes();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- id_list_interval_decoder.f -----
rtl/core/ild_pkg.sv
rtl/core/ild_csr.sv
rtl/core/ild_parser.sv
rtl/core/id_list_interval_decoder.sv
tb/tb.sv
